// ===== design/assert_macros.svh =====
// assertion macros shared by the quaternion alu modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define QA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// expression must never be true outside reset
`define QA_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// ===== design/qalu_pkg.sv =====
// shared mode codes and front-to-back status type for the quaternion alu
package qalu_pkg;

  localparam logic [3:0] MODE_ADD   = 4'd0;
  localparam logic [3:0] MODE_SUB   = 4'd1;
  localparam logic [3:0] MODE_MUL   = 4'd2;
  localparam logic [3:0] MODE_DIV   = 4'd3;
  localparam logic [3:0] MODE_INV   = 4'd4;
  localparam logic [3:0] MODE_CONJ  = 4'd5;
  localparam logic [3:0] MODE_NEG   = 4'd6;
  localparam logic [3:0] MODE_SCALE = 4'd7;
  localparam logic [3:0] MODE_DOT   = 4'd8;
  localparam logic [3:0] MODE_NORM  = 4'd9;

  typedef struct packed {
    logic valid;
    logic iter;
  } qalu_head_t;

endpackage

// ===== design/qalu_front.sv =====
// request queue of two entries with classification of iterative modes
module qalu_front
  import qalu_pkg::*;
#(
  parameter int W = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [3:0]          mode,
  input  logic signed [W-1:0] a_in [4],
  input  logic signed [W-1:0] b_in [4],
  input  logic                pop,
  output qalu_head_t          head,
  output logic [3:0]          head_mode,
  output logic signed [W-1:0] head_a [4],
  output logic signed [W-1:0] head_b [4]
);
  `include "assert_macros.svh"

  logic [3:0]          ent_mode [2];
  logic signed [W-1:0] ent_a [2][4];
  logic signed [W-1:0] ent_b [2][4];
  logic                wr_ptr;
  logic                rd_ptr;
  logic [1:0]          count;
  logic                push;

  assign busy = (count == 2'd2);
  assign push = start && !busy;

  always_ff @(posedge clk) begin
    if (push) begin
      ent_mode[wr_ptr] <= mode;
      ent_a[wr_ptr]    <= a_in;
      ent_b[wr_ptr]    <= b_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_comb begin
    head_mode  = ent_mode[rd_ptr];
    head_a     = ent_a[rd_ptr];
    head_b     = ent_b[rd_ptr];
    head.valid = (count != 2'd0);
    head.iter  = head_mode inside {MODE_INV, MODE_DIV};
  end

  `QA_ASSERT(a_count_bound, clk, rst, count <= 2'd2 && !(pop && count == 2'd0), "queue count out of range")

endmodule

// ===== design/qalu_mul.sv =====
// product array stage and combine/saturate logic for the quaternion alu
module qalu_mul
  import qalu_pkg::*;
#(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [3:0]            in_mode,
  input  logic                  in_final,
  input  logic                  in_ovf,
  input  logic signed [W-1:0]   x [4],
  input  logic signed [W-1:0]   y [4],
  output logic                  res_valid,
  output logic signed [W-1:0]   res [4],
  output logic                  res_ovf,
  output logic                  nrm_valid,
  output logic signed [2*W+1:0] nrm_val
);
  localparam int P = 2 * W;
  localparam int S = 2 * W + 2;
  localparam logic signed [S-1:0] SMAX = {{(S-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [S-1:0] SMIN = ~SMAX;

  logic                s1_valid;
  logic [3:0]          s1_mode;
  logic                s1_final;
  logic                s1_ovf;
  logic signed [W-1:0] s1_x [4];
  logic signed [W-1:0] s1_y [4];
  logic signed [P-1:0] prod [4][4];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_mode  <= in_mode;
    s1_final <= in_final;
    s1_ovf   <= in_ovf;
    s1_x     <= x;
    s1_y     <= y;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        prod[i][j] <= x[i] * y[j];
      end
    end
  end

  function automatic logic [W:0] sat_s(input logic signed [S-1:0] v);
    logic [W:0] r;
    if (v > SMAX) r = {1'b1, SMAX[W-1:0]};
    else if (v < SMIN) r = {1'b1, SMIN[W-1:0]};
    else r = {1'b0, v[W-1:0]};
    return r;
  endfunction

  logic signed [S-1:0] f [4][4];
  logic signed [S-1:0] xe [4];
  logic signed [S-1:0] ye [4];
  logic signed [S-1:0] rw [4];
  logic [W:0]          sv [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      xe[i] = S'(s1_x[i]);
      ye[i] = S'(s1_y[i]);
      rw[i] = '0;
      for (int j = 0; j < 4; j++) begin
        f[i][j] = S'(prod[i][j] >>> F);
      end
    end
    nrm_val = f[0][0] + f[1][1] + f[2][2] + f[3][3];
    case (s1_mode)
      MODE_ADD: begin
        for (int i = 0; i < 4; i++) rw[i] = xe[i] + ye[i];
      end
      MODE_SUB: begin
        for (int i = 0; i < 4; i++) rw[i] = xe[i] - ye[i];
      end
      MODE_MUL: begin
        rw[0] = f[0][0] - f[1][1] - f[2][2] - f[3][3];
        rw[1] = f[0][1] + f[1][0] + f[2][3] - f[3][2];
        rw[2] = f[0][2] - f[1][3] + f[2][0] + f[3][1];
        rw[3] = f[0][3] + f[1][2] - f[2][1] + f[3][0];
      end
      MODE_CONJ: begin
        rw[0] = xe[0];
        for (int i = 1; i < 4; i++) rw[i] = -xe[i];
      end
      MODE_NEG: begin
        for (int i = 0; i < 4; i++) rw[i] = -xe[i];
      end
      MODE_SCALE: begin
        for (int i = 0; i < 4; i++) rw[i] = f[i][0];
      end
      MODE_DOT, MODE_NORM: begin
        rw[0] = nrm_val;
      end
      default: begin
        for (int i = 0; i < 4; i++) rw[i] = '0;
      end
    endcase
    res_ovf = s1_ovf;
    for (int i = 0; i < 4; i++) begin
      sv[i]   = sat_s(rw[i]);
      res[i]  = sv[i][W-1:0];
      res_ovf = res_ovf | sv[i][W];
    end
    res_valid = s1_valid && s1_final;
    nrm_valid = s1_valid && !s1_final;
  end

endmodule

// ===== design/qalu_div.sv =====
// four-lane restoring divider forming the inverse components c * 2^F / n
module qalu_div #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic signed [2*W+1:0] n,
  input  logic [W-1:0]          c_mag [4],
  input  logic                  c_neg [4],
  output logic                  done,
  output logic signed [W-1:0]   q [4],
  output logic                  ovf
);
  localparam int S  = 2 * W + 2;
  localparam int DW = W + F;
  localparam int CW = $clog2(DW + 1);
  localparam logic [DW-1:0] QMAXP = {{(F+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [DW-1:0] QMAXN = QMAXP + DW'(1);
  localparam logic [W-1:0]  VMAX  = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  VMIN  = {1'b1, {(W-1){1'b0}}};

  logic          running;
  logic [CW-1:0] cnt;
  logic [S:0]    dvs;
  logic [S:0]    rem [4];
  logic [DW-1:0] dvd [4];
  logic [DW-1:0] quo [4];
  logic          neg [4];
  logic [S:0]    trial [4];

  always_comb begin
    for (int t = 0; t < 4; t++) trial[t] = {rem[t][S-1:0], dvd[t][DW-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(DW - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= {1'b0, n};
      for (int t = 0; t < 4; t++) begin
        rem[t] <= '0;
        quo[t] <= '0;
        dvd[t] <= DW'(c_mag[t]) << F;
        neg[t] <= c_neg[t];
      end
    end else if (running) begin
      for (int t = 0; t < 4; t++) begin
        dvd[t] <= dvd[t] << 1;
        if (trial[t] >= dvs) begin
          rem[t] <= trial[t] - dvs;
          quo[t] <= {quo[t][DW-2:0], 1'b1};
        end else begin
          rem[t] <= trial[t];
          quo[t] <= {quo[t][DW-2:0], 1'b0};
        end
      end
    end
  end

  // sign and saturate the quotient magnitudes
  always_comb begin
    ovf = 1'b0;
    for (int t = 0; t < 4; t++) begin
      if (neg[t]) begin
        if (quo[t] > QMAXN) begin
          q[t] = VMIN;
          ovf  = 1'b1;
        end else begin
          q[t] = -quo[t][W-1:0];
        end
      end else begin
        if (quo[t] > QMAXP) begin
          q[t] = VMAX;
          ovf  = 1'b1;
        end else begin
          q[t] = quo[t][W-1:0];
        end
      end
    end
  end

endmodule

// ===== design/qalu_back.sv =====
// execution side: issue control, product pipeline, divider and result register
module qalu_back
  import qalu_pkg::*;
#(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  qalu_head_t          head,
  input  logic [3:0]          head_mode,
  input  logic signed [W-1:0] head_a [4],
  input  logic signed [W-1:0] head_b [4],
  output logic                pop,
  output logic                strobe,
  output logic signed [W-1:0] res [4],
  output logic                overflow,
  output logic                div_by_zero
);
  `include "assert_macros.svh"

  typedef enum logic [1:0] {ST_IDLE, ST_NORM, ST_DIV} state_t;

  state_t              state;
  logic [3:0]          hmode;
  logic signed [W-1:0] ha [4];
  logic signed [W-1:0] hb [4];

  logic                iss_valid;
  logic [3:0]          iss_mode;
  logic                iss_final;
  logic                iss_ovf;
  logic signed [W-1:0] x [4];
  logic signed [W-1:0] y [4];

  logic                  res_fin;
  logic signed [W-1:0]   mres [4];
  logic                  mres_ovf;
  logic                  nrm_valid;
  logic signed [2*W+1:0] nrm_val;

  logic                div_start;
  logic                div_done;
  logic signed [W-1:0] dq [4];
  logic                dovf;
  logic [W-1:0]        c_mag [4];
  logic                c_neg [4];
  logic signed [W-1:0] src [4];
  logic                emit;
  logic                emit_dz;

  qalu_mul #(.W(W), .F(F)) u_mul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (iss_valid),
    .in_mode   (iss_mode),
    .in_final  (iss_final),
    .in_ovf    (iss_ovf),
    .x         (x),
    .y         (y),
    .res_valid (res_fin),
    .res       (mres),
    .res_ovf   (mres_ovf),
    .nrm_valid (nrm_valid),
    .nrm_val   (nrm_val)
  );

  qalu_div #(.W(W), .F(F)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .n     (nrm_val),
    .c_mag (c_mag),
    .c_neg (c_neg),
    .done  (div_done),
    .q     (dq),
    .ovf   (dovf)
  );

  // conjugate of the quaternion being inverted, as magnitude and sign
  always_comb begin
    for (int t = 0; t < 4; t++) begin
      src[t]   = (hmode == MODE_DIV) ? hb[t] : ha[t];
      c_mag[t] = src[t][W-1] ? -src[t] : src[t];
      if (t == 0) c_neg[t] = src[t][W-1];
      else c_neg[t] = !src[t][W-1] && (src[t] != '0);
    end
  end

  always_comb begin
    pop       = 1'b0;
    iss_valid = 1'b0;
    iss_mode  = head_mode;
    iss_final = 1'b1;
    iss_ovf   = 1'b0;
    x         = head_a;
    y         = head_b;
    div_start = 1'b0;
    emit      = 1'b0;
    emit_dz   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (head.valid) begin
          pop       = 1'b1;
          iss_valid = 1'b1;
          if (head.iter) begin
            iss_mode  = MODE_NORM;
            iss_final = 1'b0;
            for (int t = 0; t < 4; t++) begin
              x[t] = (head_mode == MODE_DIV) ? head_b[t] : head_a[t];
              y[t] = x[t];
            end
          end else if (head_mode == MODE_NORM) begin
            y = head_a;
          end
        end
      end
      ST_NORM: begin
        if (nrm_valid) begin
          if (nrm_val == '0) begin
            emit    = 1'b1;
            emit_dz = 1'b1;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (hmode == MODE_DIV) begin
            iss_valid = 1'b1;
            iss_mode  = MODE_MUL;
            iss_ovf   = dovf;
            x         = ha;
            y         = dq;
          end else begin
            emit = 1'b1;
          end
        end
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      strobe <= 1'b0;
    end else begin
      strobe <= res_fin || emit;
      case (state)
        ST_IDLE: begin
          if (head.valid && head.iter) state <= ST_NORM;
        end
        ST_NORM: begin
          if (nrm_valid) state <= (nrm_val == '0) ? ST_IDLE : ST_DIV;
        end
        ST_DIV: begin
          if (div_done) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
    if (pop) begin
      hmode <= head_mode;
      ha    <= head_a;
      hb    <= head_b;
    end
    if (res_fin) begin
      res         <= mres;
      overflow    <= mres_ovf;
      div_by_zero <= 1'b0;
    end else if (emit) begin
      for (int t = 0; t < 4; t++) res[t] <= emit_dz ? '0 : dq[t];
      overflow    <= emit_dz ? 1'b0 : dovf;
      div_by_zero <= emit_dz;
    end
  end

  `QA_NEVER(a_no_collide, clk, rst, res_fin && emit, "pipeline result and direct result collide")
  `QA_ASSERT(a_div_nonzero, clk, rst, div_start |-> nrm_val != '0, "divider started on zero norm")

endmodule

// ===== design/quaternion_fixed_point_alu_top.sv =====
// top level of the quaternion fixed-point alu
//
// usage:
//  - a request (mode plus quaternions a and b) is taken on a rising edge
//    where start is high and busy is low; busy only rises when the
//    two-entry request queue is full
//  - each result is shown on res_r/res_i/res_j/res_k, overflow and
//    div_by_zero for exactly one cycle with strobe high; the receiver
//    cannot hold it off, so it must capture it in that cycle
//  - add, sub, mul, conj, neg, scale, dot and norm squared run through a
//    product array stage and a combine/saturate stage into the result
//    register, one request per cycle sustained while no inv or div runs
//  - inv and div go through the restoring divider, one quotient bit per
//    cycle on four lanes, and div then through the product array;
//    requests behind them wait in the queue
//  - results leave in request order
//  - rst (synchronous, active high) empties the queue and drops any work
//    in flight; no result strobes while it is held
module quaternion_fixed_point_alu_top
  import qalu_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [3:0]                   mode,
  input  logic signed [DATA_WIDTH-1:0] a_r,
  input  logic signed [DATA_WIDTH-1:0] a_i,
  input  logic signed [DATA_WIDTH-1:0] a_j,
  input  logic signed [DATA_WIDTH-1:0] a_k,
  input  logic signed [DATA_WIDTH-1:0] b_r,
  input  logic signed [DATA_WIDTH-1:0] b_i,
  input  logic signed [DATA_WIDTH-1:0] b_j,
  input  logic signed [DATA_WIDTH-1:0] b_k,
  output logic                         strobe,
  output logic signed [DATA_WIDTH-1:0] res_r,
  output logic signed [DATA_WIDTH-1:0] res_i,
  output logic signed [DATA_WIDTH-1:0] res_j,
  output logic signed [DATA_WIDTH-1:0] res_k,
  output logic                         overflow,
  output logic                         div_by_zero
);
  `include "assert_macros.svh"

  // operand bundles in r, i, j, k order
  logic signed [DATA_WIDTH-1:0] a_in [4];
  logic signed [DATA_WIDTH-1:0] b_in [4];
  logic signed [DATA_WIDTH-1:0] head_a [4];
  logic signed [DATA_WIDTH-1:0] head_b [4];
  logic signed [DATA_WIDTH-1:0] res [4];
  logic [3:0]                   head_mode;
  qalu_head_t                   head;
  logic                         pop;

  assign a_in = '{a_r, a_i, a_j, a_k};
  assign b_in = '{b_r, b_i, b_j, b_k};

  // front: request queue, flags inv and div as iterative work
  qalu_front #(.W(DATA_WIDTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .mode      (mode),
    .a_in      (a_in),
    .b_in      (b_in),
    .pop       (pop),
    .head      (head),
    .head_mode (head_mode),
    .head_a    (head_a),
    .head_b    (head_b)
  );

  // back: pipeline, divider and the result register
  qalu_back #(.W(DATA_WIDTH), .F(FRAC_BITS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .head_mode   (head_mode),
    .head_a      (head_a),
    .head_b      (head_b),
    .pop         (pop),
    .strobe      (strobe),
    .res         (res),
    .overflow    (overflow),
    .div_by_zero (div_by_zero)
  );

  assign res_r = res[0];
  assign res_i = res[1];
  assign res_j = res[2];
  assign res_k = res[3];

  // a zero-norm result is all zero with no overflow
  `QA_ASSERT(a_dz_clean, clk, rst, strobe && div_by_zero |-> !overflow && res_r == '0 && res_k == '0, "zero norm result not cleared")

endmodule

// ===== sim/quaternion_fixed_point_alu_checker.sv =====
`timescale 1ns / 100ps
// result predictor and scoreboard for the quaternion fixed-point alu
module quaternion_fixed_point_alu_checker
  import qalu_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [3:0]         mode,
  input  logic signed [31:0] a_r,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] a_j,
  input  logic signed [31:0] a_k,
  input  logic signed [31:0] b_r,
  input  logic signed [31:0] b_i,
  input  logic signed [31:0] b_j,
  input  logic signed [31:0] b_k,
  input  logic               strobe,
  input  logic signed [31:0] res_r,
  input  logic signed [31:0] res_i,
  input  logic signed [31:0] res_j,
  input  logic signed [31:0] res_k,
  input  logic               overflow,
  input  logic               div_by_zero,
  output int                 errors,
  output int                 pending,
  output int                 results_seen
);

  typedef struct {
    logic signed [31:0] q [4];
    logic               ovf;
    logic               dz;
  } quat_result_t;

  typedef longint quad_t [4];

  quat_result_t result_queue [$];
  bit           clip_hit;

  function automatic longint qmul(longint x, longint y);
    qmul = (x * y) >>> 16;
  endfunction

  function automatic longint clip(longint v);
    if (v > 64'sd2147483647) begin
      clip_hit = 1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      clip_hit = 1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic string field_name(int t);
    case (t)
      0: return "res_r";
      1: return "res_i";
      2: return "res_j";
      default: return "res_k";
    endcase
  endfunction

  function automatic void hamilton_prod(input quad_t x, input quad_t y, output quad_t z);
    z[0] = clip(qmul(x[0], y[0]) - qmul(x[1], y[1]) - qmul(x[2], y[2]) - qmul(x[3], y[3]));
    z[1] = clip(qmul(x[0], y[1]) + qmul(x[1], y[0]) + qmul(x[2], y[3]) - qmul(x[3], y[2]));
    z[2] = clip(qmul(x[0], y[2]) - qmul(x[1], y[3]) + qmul(x[2], y[0]) + qmul(x[3], y[1]));
    z[3] = clip(qmul(x[0], y[3]) + qmul(x[1], y[2]) - qmul(x[2], y[1]) + qmul(x[3], y[0]));
  endfunction

  function automatic longint sq_norm(input quad_t x);
    sq_norm = qmul(x[0], x[0]) + qmul(x[1], x[1]) + qmul(x[2], x[2]) + qmul(x[3], x[3]);
  endfunction

  // zero norm returns 0, quotient truncates toward zero
  function automatic bit reciprocal(input quad_t x, output quad_t z);
    longint n;
    longint c;
    n = sq_norm(x);
    if (n == 0) return 0;
    for (int t = 0; t < 4; t++) begin
      c = (t == 0) ? x[0] : -x[t];
      z[t] = clip((c * 64'sd65536) / n);
    end
    return 1;
  endfunction

  function automatic quat_result_t predict_quat(logic [3:0] m, quad_t x, quad_t y);
    quat_result_t r;
    quad_t z;
    quad_t rcp;
    bit dz;
    dz = 0;
    clip_hit = 0;
    for (int t = 0; t < 4; t++) z[t] = 0;
    case (m)
      MODE_ADD:   for (int t = 0; t < 4; t++) z[t] = clip(x[t] + y[t]);
      MODE_SUB:   for (int t = 0; t < 4; t++) z[t] = clip(x[t] - y[t]);
      MODE_MUL:   hamilton_prod(x, y, z);
      MODE_DIV: begin
        if (reciprocal(y, rcp)) hamilton_prod(x, rcp, z);
        else dz = 1;
      end
      MODE_INV:   if (!reciprocal(x, z)) dz = 1;
      MODE_CONJ: begin
        z[0] = x[0];
        for (int t = 1; t < 4; t++) z[t] = clip(-x[t]);
      end
      MODE_NEG:   for (int t = 0; t < 4; t++) z[t] = clip(-x[t]);
      MODE_SCALE: for (int t = 0; t < 4; t++) z[t] = clip(qmul(x[t], y[0]));
      MODE_DOT:
        z[0] = clip(qmul(x[0], y[0]) + qmul(x[1], y[1]) + qmul(x[2], y[2]) + qmul(x[3], y[3]));
      MODE_NORM:  z[0] = clip(sq_norm(x));
      default: ;
    endcase
    if (dz) begin
      clip_hit = 0;
      for (int t = 0; t < 4; t++) z[t] = 0;
    end
    for (int t = 0; t < 4; t++) r.q[t] = z[t][31:0];
    r.ovf = clip_hit;
    r.dz  = dz;
    return r;
  endfunction

  always @(posedge clk) begin
    quad_t x;
    quad_t y;
    quat_result_t want;
    logic signed [31:0] got [4];
    int miss;
    miss = 0;
    if (rst) begin
      result_queue.delete();
      errors       <= 0;
      results_seen <= 0;
      pending      <= 0;
    end else begin
      if (start && !busy) begin
        x = '{a_r, a_i, a_j, a_k};
        y = '{b_r, b_i, b_j, b_k};
        result_queue.push_back(predict_quat(mode, x, y));
      end
      if (strobe) begin
        results_seen <= results_seen + 1;
        if (result_queue.size() == 0) begin
          $error("result with no request outstanding");
          miss++;
        end else begin
          want = result_queue.pop_front();
          got  = '{res_r, res_i, res_j, res_k};
          foreach (got[t]) begin
            if (got[t] !== want.q[t]) begin
              $error("%s expected %0d actual %0d", field_name(t), want.q[t], got[t]);
              miss++;
            end
          end
          if (overflow !== want.ovf) begin
            $error("overflow expected %0b actual %0b", want.ovf, overflow);
            miss++;
          end
          if (div_by_zero !== want.dz) begin
            $error("div_by_zero expected %0b actual %0b", want.dz, div_by_zero);
            miss++;
          end
        end
      end
      errors  <= errors + miss;
      pending <= result_queue.size();
    end
  end

endmodule

// ===== sim/quaternion_fixed_point_alu_top_test.sv =====
`timescale 1ns / 100ps
// stimulus and verdict for the quaternion fixed-point alu
module quaternion_fixed_point_alu_top_test;
  import qalu_pkg::*;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic [3:0] mode;
  logic signed [31:0] a_r, a_i, a_j, a_k, b_r, b_i, b_j, b_k;
  logic strobe;
  logic signed [31:0] res_r, res_i, res_j, res_k;
  logic overflow, div_by_zero;
  int errors, pending, results_seen;
  int requests_sent;

  localparam logic signed [31:0] MAXV = 32'sh7fffffff;
  localparam logic signed [31:0] MINV = 32'sh80000000;
  localparam logic signed [31:0] ONE  = 32'sh00010000;

  // clock: 10 ns period
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  quaternion_fixed_point_alu_top u_top (
    .clk, .rst, .start, .busy, .mode,
    .a_r, .a_i, .a_j, .a_k, .b_r, .b_i, .b_j, .b_k,
    .strobe, .res_r, .res_i, .res_j, .res_k, .overflow, .div_by_zero
  );

  quaternion_fixed_point_alu_checker u_checker (
    .clk, .rst, .start, .busy, .mode,
    .a_r, .a_i, .a_j, .a_k, .b_r, .b_i, .b_j, .b_k,
    .strobe, .res_r, .res_i, .res_j, .res_k, .overflow, .div_by_zero,
    .errors, .pending, .results_seen
  );

  // random operand with a bias toward values that matter for fixed point
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return MAXV;
      1: return MINV;
      2: return 32'($urandom_range(0, 3)) - 32'sd1;
      3: return $urandom_range(0, 1) ? ONE : -ONE;
      4, 5: return $signed(32'($urandom_range(0, 32'h3ffff))) - 32'sh20000;
      6: return $signed(32'($urandom_range(0, 511))) - 32'sd256;
      default: return $signed($urandom());
    endcase
  endfunction

  // hold one request on the ports until it is taken, then drop start unless keep_start is set
  task automatic send_request(logic [3:0] m, logic signed [31:0] q [8], bit keep_start);
    mode <= m;
    {a_r, a_i, a_j, a_k} <= {q[0], q[1], q[2], q[3]};
    {b_r, b_i, b_j, b_k} <= {q[4], q[5], q[6], q[7]};
    start <= 1'b1;
    do @(posedge clk); while (busy);
    requests_sent++;
    @(negedge clk);
    if (!keep_start) start <= 1'b0;
  endtask

  initial begin
    logic signed [31:0] ops [8];
    logic [3:0] m;
    int burst;
    rst   = 1'b1;
    start = 1'b0;
    mode  = MODE_ADD;
    {a_r, a_i, a_j, a_k, b_r, b_i, b_j, b_k} = '0;
    requests_sent = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, each mode, zero norm, tiny norm, negating the minimum
    for (int d = 0; d < 16; d++) begin
      m = d[3:0];
      foreach (ops[t]) ops[t] = (t < 4) ? MAXV : MINV;
      send_request(m, ops, 0);
      foreach (ops[t]) ops[t] = (t % 2) ? MINV : ONE;
      send_request(m, ops, 1);
    end
    // zero norm and a norm lost to truncation for inv and div
    foreach (ops[t]) ops[t] = 0;
    send_request(MODE_INV, ops, 1);
    send_request(MODE_DIV, ops, 1);
    foreach (ops[t]) ops[t] = 32'sd1;
    send_request(MODE_INV, ops, 1);
    send_request(MODE_DIV, ops, 0);

    // random part: bursts with random gaps, mostly legal modes
    while (requests_sent < 1650) begin
      burst = $urandom_range(1, 12);
      for (int n = 0; n < burst; n++) begin
        m = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                         : 4'($urandom_range(0, 9));
        foreach (ops[t]) ops[t] = pick_value();
        send_request(m, ops, n != burst - 1);
      end
      if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 20)) @(negedge clk);
    end

    // drain outstanding results, then allow the pipeline to settle
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("covered %0d requests over all ten modes, unused codes and flag cases",
             requests_sent);
    $display("checked %0d results", results_seen);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // safety net on total run time
  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

endmodule
